// File: sv/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Request and result items, status codes and config register indexes.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // fixed field widths
    localparam int LEN_W      = 21;   // request size / record length
    localparam int ADDR_W     = 32;   // bus addresses
    localparam int CNT_OUT_W  = 7;    // blocks_in_use field
    localparam int STAT_W     = 3;
    localparam int S_TDATA_W  = 56;   // size + free address, byte padded
    localparam int M_TDATA_W  = 40;   // address + blocks in use, byte padded
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 1'b1;

    localparam logic [LEN_W-1:0] REGION_SIZE_RST = 21'd1048576;

    // request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_HOLE   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_ZERO      = 3'd4
    } t_status;

    typedef struct packed {
        logic              action;
        logic [LEN_W-1:0]  size;
        logic [ADDR_W-1:0] faddr;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [ADDR_W-1:0]    addr;
        logic [CNT_OUT_W-1:0] in_use;
    } t_res;

endpackage

// File: sv/ffba_rec_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_rec_mem: block record memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ffba_rec_mem #(
    parameter int DEPTH = 64,
    parameter int DW    = 41,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/ffba_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_engine: scan and shift sequencer of the allocator
// Walks the sorted record memory for a gap or an address match, then moves
// the tail of the table up (insert) or down (remove) one entry per cycle.
// ----------------------------------------------------------------------------
module ffba_engine #(
    parameter int MAX_BLOCKS  = 64,
    parameter int OFFSET_BITS = 20,
    parameter int AW          = 6,
    parameter int DW          = 41
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request side
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  ffba_pkg::t_req                 i_req,
    // configuration
    input  logic [ffba_pkg::ADDR_W-1:0]    i_region_base,
    input  logic [ffba_pkg::LEN_W-1:0]     i_region_size,
    // result side
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output ffba_pkg::t_res                 o_res,
    // record memory
    output logic                           o_mem_we,
    output logic [AW-1:0]                  o_mem_waddr,
    output logic [DW-1:0]                  o_mem_wdata,
    output logic                           o_mem_re,
    output logic [AW-1:0]                  o_mem_raddr,
    input  logic [DW-1:0]                  i_mem_rdata
);

    localparam int LW = ffba_pkg::LEN_W;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    // gap bounds and block ends
    localparam int EW = ((OFFSET_BITS > LW) ? OFFSET_BITS : LW) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_RESP
    } t_state;

    t_state                        r_state;
    logic                          r_act;
    logic [LW-1:0]                 r_size;
    logic [ffba_pkg::ADDR_W-1:0]   r_faddr;
    logic [EW-1:0]                 r_end;
    logic [EW-1:0]                 r_low;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 r_rd;
    logic [CW-1:0]                 r_ev;
    logic                          r_dv;
    logic [CW-1:0]                 r_pos;
    ffba_pkg::t_status             r_status;
    logic [ffba_pkg::ADDR_W-1:0]   r_addr;

    logic [OFFSET_BITS-1:0]        rec_off;
    logic [LW-1:0]                 rec_len;
    logic [EW-1:0]                 lim;
    logic [EW-1:0]                 size_ext;
    logic [EW-1:0]                 n_end;
    logic                          at_end;
    logic [EW-1:0]                 gap_hi;
    logic [EW-1:0]                 gap;
    logic                          fit;
    logic [EW-1:0]                 n_low;
    logic                          hit;
    logic                          scan_up;
    logic                          scan_dn;
    logic [CW-1:0]                 rd_dec;
    logic [CW-1:0]                 ev_inc;
    logic [CW-1:0]                 ev_dec;
    logic                          rd_en;
    logic                          accept;

    assign rec_off = i_mem_rdata[DW-1:LW];
    assign rec_len = i_mem_rdata[LW-1:0];

    // usable region end, saturated to the offset range
    assign lim      = EW'(1) << OFFSET_BITS;
    assign size_ext = EW'(i_region_size);
    assign n_end    = (size_ext > lim) ? lim : size_ext;

    // gap evaluation for the entry in flight (or the region end)
    assign at_end = (r_ev == r_count);
    assign gap_hi = at_end ? r_end : EW'(rec_off);
    assign gap    = (gap_hi > r_low) ? (gap_hi - r_low) : '0;
    assign fit    = (EW'(r_size) <= gap);
    assign n_low  = EW'(rec_off) + EW'(rec_len);

    // free match against the current base
    assign hit = ((i_region_base + ffba_pkg::ADDR_W'(rec_off)) == r_faddr);

    // scan exits: slot found for an allocate, record found for a free
    assign scan_up = (r_act == ffba_pkg::ACT_ALLOC) && (at_end || r_dv) && fit;
    assign scan_dn = (r_act == ffba_pkg::ACT_FREE) && !at_end && r_dv && hit;

    assign rd_dec = r_rd - CW'(1);
    assign ev_inc = r_ev + CW'(1);
    assign ev_dec = r_ev - CW'(1);

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;

    // memory access sequencing
    always_comb begin
        rd_en       = 1'b0;
        o_mem_raddr = r_rd[AW-1:0];
        o_mem_we    = 1'b0;
        o_mem_waddr = ev_inc[AW-1:0];
        o_mem_wdata = i_mem_rdata;
        case (r_state)
            S_SCAN: begin
                rd_en = (r_rd < r_count);
            end
            S_SHIFT_UP: begin
                rd_en       = (r_rd > r_pos);
                o_mem_raddr = rd_dec[AW-1:0];
                if (r_dv) begin
                    o_mem_we = 1'b1;
                end else if (!rd_en) begin
                    // tail moved: drop the new record into its slot
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_pos[AW-1:0];
                    o_mem_wdata = {r_low[OFFSET_BITS-1:0], r_size};
                end
            end
            S_SHIFT_DN: begin
                rd_en       = (r_rd < r_count);
                o_mem_we    = r_dv;
                o_mem_waddr = ev_dec[AW-1:0];
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign o_mem_re = rd_en;

    // result item
    assign o_res_valid   = (r_state == S_RESP);
    assign o_res.status  = r_status;
    assign o_res.addr    = r_addr;
    assign o_res.in_use  = ffba_pkg::CNT_OUT_W'(r_count);

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_dv    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_act    <= i_req.action;
                        r_size   <= i_req.size;
                        r_faddr  <= i_req.faddr;
                        r_end    <= n_end;
                        r_low    <= '0;
                        r_rd     <= '0;
                        r_ev     <= '0;
                        r_dv     <= 1'b0;
                        r_addr   <= '0;
                        if (i_req.action == ffba_pkg::ACT_ALLOC && i_req.size == '0) begin
                            r_status <= ffba_pkg::ST_ZERO;
                            r_state  <= S_RESP;
                        end else if (i_req.action == ffba_pkg::ACT_ALLOC &&
                                     r_count == CW'(MAX_BLOCKS)) begin
                            r_status <= ffba_pkg::ST_FULL;
                            r_state  <= S_RESP;
                        end else begin
                            r_status <= ffba_pkg::ST_OK;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_up) begin
                        r_pos   <= r_ev;
                        r_addr  <= i_region_base + ffba_pkg::ADDR_W'(r_low);
                        r_rd    <= r_count;
                        r_dv    <= 1'b0;
                        r_state <= S_SHIFT_UP;
                    end else if (scan_dn) begin
                        r_pos   <= r_ev;
                        r_rd    <= ev_inc;
                        r_dv    <= 1'b0;
                        r_state <= S_SHIFT_DN;
                    end else begin
                        r_dv <= rd_en;
                        if (rd_en) begin
                            r_rd <= r_rd + CW'(1);
                        end
                        if (at_end) begin
                            if (r_act == ffba_pkg::ACT_ALLOC) begin
                                r_status <= ffba_pkg::ST_NO_HOLE;
                            end else begin
                                r_status <= ffba_pkg::ST_NOT_FOUND;
                            end
                            r_state <= S_RESP;
                        end else if (r_dv) begin
                            // next gap starts at the end of this block
                            r_low <= n_low;
                            r_ev  <= ev_inc;
                        end
                    end
                end
                S_SHIFT_UP: begin
                    r_dv <= rd_en;
                    if (rd_en) begin
                        r_rd <= rd_dec;
                        r_ev <= rd_dec;
                    end
                    if (!rd_en && !r_dv) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_RESP;
                    end
                end
                S_SHIFT_DN: begin
                    r_dv <= rd_en;
                    if (rd_en) begin
                        r_rd <= r_rd + CW'(1);
                        r_ev <= r_rd;
                    end
                    if (!rd_en && !r_dv) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit allocator over one memory region
//
// Input stream: one request item per handshake; tuser selects allocate (0)
// or free (1), tdata carries the request size and the address to free.
// Output stream: one result item per request with status in tuser, the
// allocated address and the number of blocks in use in tdata.
// Config port: region base (index 0) and region size (index 1); the user is
// to write them only while no request is in progress (the block does not enforce this).
// Block records (offset, length) live address-sorted in a 1R1W memory with
// registered read data. An allocate reads one record a cycle until a gap
// fits, then shifts the tail up one entry per cycle; a free scans for the
// address and shifts the tail down. A zero-size or table-full allocate
// skips the scan and goes straight to its result.
// Reset empties the table (count cleared), base 0, size 1 MiB; no memory
// clearing pass is needed. A finished result sits in an output register;
// the next request is taken while it waits, but its own result is held
// back until the receiver takes the previous one.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS  = 64,
    parameter int OFFSET_BITS = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [ffba_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,  // request_size, free_address
    input  logic                                i_s_axis_tuser,  // action
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [ffba_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,  // block_address, blocks_in_use
    output logic [ffba_pkg::STAT_W-1:0]         o_m_axis_tuser,  // status
    // configuration
    input  logic                                i_cfg_we,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ffba_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int LW = ffba_pkg::LEN_W;
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int DW = OFFSET_BITS + LW;

    logic [ffba_pkg::ADDR_W-1:0] r_region_base;
    logic [LW-1:0]               r_region_size;
    logic                        r_m_valid;
    ffba_pkg::t_res              r_m_res;

    ffba_pkg::t_req              req;
    ffba_pkg::t_res              res;
    logic                        res_valid;
    logic                        res_ready;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [DW-1:0]               mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [DW-1:0]               mem_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base <= '0;
            r_region_size <= ffba_pkg::REGION_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ffba_pkg::CFG_REGION_BASE: r_region_base <= i_cfg_wdata;
                ffba_pkg::CFG_REGION_SIZE: r_region_size <= i_cfg_wdata[LW-1:0];
                default: ;
            endcase
        end
    end

    // unpack request item
    assign req.action = i_s_axis_tuser;
    assign req.size   = i_s_axis_tdata[LW-1:0];
    assign req.faddr  = i_s_axis_tdata[LW +: ffba_pkg::ADDR_W];

    ffba_engine #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .OFFSET_BITS (OFFSET_BITS),
        .AW          (AW),
        .DW          (DW)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_s_axis_tvalid),
        .o_req_ready   (o_s_axis_tready),
        .i_req         (req),
        .i_region_base (r_region_base),
        .i_region_size (r_region_size),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    ffba_rec_mem #(
        .DEPTH (MAX_BLOCKS),
        .DW    (DW),
        .AW    (AW)
    ) u_rec_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output register: free when empty or being taken
    assign res_ready = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_m_res.status;
    assign o_m_axis_tdata  = {1'b0, r_m_res.in_use, r_m_res.addr};

endmodule

// File: sv/ffba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_checker: port-level checks of the first-fit block allocator
// Result consistency and output stall behavior, attached by bind.
// ----------------------------------------------------------------------------
module ffba_port_checks #(
    parameter int MAX_BLOCKS  = 64,
    parameter int OFFSET_BITS = 20
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [ffba_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    input logic [ffba_pkg::STAT_W-1:0]         o_m_axis_tuser
);

    localparam logic [ffba_pkg::CNT_OUT_W-1:0] MAX_CNT = ffba_pkg::CNT_OUT_W'(MAX_BLOCKS);

    // a failed result never carries an address
    a_addr_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ffba_pkg::ST_OK)
        |-> (o_m_axis_tdata[31:0] == '0))
        else $error("nonzero address on failed request");

    // table full is only reported with every record in use
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == ffba_pkg::ST_FULL)
        |-> (o_m_axis_tdata[38:32] == MAX_CNT))
        else $error("table full reported below capacity");

    // block count bounded by the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (MAX_BLOCKS < 128)) |-> (o_m_axis_tdata[38:32] <= MAX_CNT))
        else $error("blocks in use exceeds table size");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

endmodule

bind first_fit_block_allocator ffba_port_checks #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .OFFSET_BITS (OFFSET_BITS)
) u_ffba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
